// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define PLQD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent in one cycle, consequent in the next
`define PLQD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/plqd_pkg.sv =====
// types, codes and budget table of the priority log queue drain
`timescale 1ns / 1ps

package plqd_pkg;

    localparam int NUM_CLASS   = 3;
    localparam int MAX_RESULTS = 48;
    localparam int CNT_W       = 6;
    localparam int SEQ_W       = 16;
    localparam int ENTRY_W     = 74;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [SEQ_W-1:0] SAT16 = 16'hFFFF;

    localparam logic MODE_ENQUEUE = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    localparam logic [1:0] CLS_CRIT    = 2'd0;
    localparam logic [1:0] CLS_USER    = 2'd1;
    localparam logic [1:0] CLS_BG      = 2'd2;
    localparam logic [1:0] CLS_DEFAULT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIAL_BANDWIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIFI_ENABLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIFI_BANDWIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIFI_STREAM      = 3'd4;

    localparam logic [2:0] BW_NEVER  = 3'd0;
    localparam logic [2:0] BW_LOW    = 3'd1;
    localparam logic [2:0] BW_NORMAL = 3'd2;
    localparam logic [2:0] BW_HIGH   = 3'd3;
    localparam logic [2:0] BW_FULL   = 3'd4;

    typedef struct packed {
        logic        mode;
        logic [1:0]  priority_req;
        logic [1:0]  dflt_class;
        logic [1:0]  value_type;
        logic [31:0] value;
        logic [7:0]  source_id;
        logic [31:0] timestamp;
    } plqd_in_t;

    typedef struct packed {
        logic [1:0]       priority_res;
        logic [1:0]       value_type_res;
        logic [31:0]      value_res;
        logic [7:0]       source_id_res;
        logic [31:0]      timestamp_res;
        logic             to_serial;
        logic             to_wifi;
        logic [SEQ_W-1:0] serial_seq;
        logic [SEQ_W-1:0] wifi_seq;
        logic [SEQ_W-1:0] serial_drops;
        logic [SEQ_W-1:0] wifi_drops;
        logic             last;
    } plqd_out_t;

    // samples a transport may send in one tick
    function automatic logic [SEQ_W-1:0] budget_of(input logic [2:0] bw);
        logic [SEQ_W-1:0] b;
        unique case (bw)
            BW_NEVER:  b = '0;
            BW_LOW:    b = 16'd2;
            BW_NORMAL: b = 16'd6;
            BW_HIGH:   b = 16'd12;
            BW_FULL:   b = SAT16;
            default:   b = '0;
        endcase
        return b;
    endfunction

endpackage

// ===== src/plqd_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module plqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/priority_log_queue_drain.sv =====
// Priority log queue drain: three FIFO classes (critical, user, background) of QUEUE_DEPTH
// samples each, held in one ram of 3*QUEUE_DEPTH entries with head, tail and fill per class
// in flip-flops. An enqueue beat, with eviction and drop counting, is handled in the cycle it
// is taken. A tick beat sets the budgets and drains each sample by a ram read, then an output
// load, at most 48 samples, waiting while the output is stalled; no new input beat is taken
// until the final sample of the tick is loaded into the output register. A tick that finds no
// budget or no queued sample gives no beat at all. Configuration writes are taken every cycle.
`timescale 1ns / 1ps

module priority_log_queue_drain
    import plqd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  plqd_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output plqd_out_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IW       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW       = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_D    = NUM_CLASS * QUEUE_DEPTH;
    localparam int AW       = $clog2(RAM_D);
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam logic [FW-1:0] FULL     = FW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] BASE1    = AW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] BASE2    = AW'(2 * QUEUE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    typedef struct packed {
        logic [1:0]       cls;
        logic             to_serial;
        logic             to_wifi;
        logic [SEQ_W-1:0] serial_seq;
        logic [SEQ_W-1:0] wifi_seq;
        logic [SEQ_W-1:0] serial_drops;
        logic [SEQ_W-1:0] wifi_drops;
        logic             last;
    } meta_t;

    function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : IW'(idx + 1'b1);
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [1:0] cls, input logic [IW-1:0] idx);
        logic [AW-1:0] base;
        base = (cls == CLS_CRIT) ? '0 : (cls == CLS_USER) ? BASE1 : BASE2;
        return AW'(base + AW'(idx));
    endfunction

    function automatic logic [SEQ_W-1:0] sat_add(input logic [SEQ_W-1:0] v,
                                                input logic [1:0] amt);
        logic [SEQ_W:0] s;
        s = {1'b0, v} + (SEQ_W + 1)'(amt);
        return s[SEQ_W] ? SAT16 : s[SEQ_W-1:0];
    endfunction

    logic [1:0]       state_reg, state_next;
    logic             serial_en_reg, wifi_en_reg, wifi_stream_reg;
    logic [2:0]       serial_bw_reg, wifi_bw_reg;
    logic [IW-1:0]    head_reg [NUM_CLASS];
    logic [IW-1:0]    head_next [NUM_CLASS];
    logic [IW-1:0]    tail_reg [NUM_CLASS];
    logic [IW-1:0]    tail_next [NUM_CLASS];
    logic [FW-1:0]    fill_reg [NUM_CLASS];
    logic [FW-1:0]    fill_next [NUM_CLASS];
    logic [SEQ_W-1:0] serial_seq_reg, serial_seq_next;
    logic [SEQ_W-1:0] wifi_seq_reg, wifi_seq_next;
    logic [SEQ_W-1:0] serial_drop_reg, serial_drop_next;
    logic [SEQ_W-1:0] wifi_drop_reg, wifi_drop_next;
    logic [SEQ_W-1:0] sb_reg, sb_next;
    logic [SEQ_W-1:0] wb_reg, wb_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    meta_t            meta_reg, meta_next;
    plqd_out_t        out_reg;
    logic             out_valid_reg, out_valid_next;

    logic               accept_in;
    logic [1:0]         enq_cls;
    logic [1:0]         pop_cls;
    logic [1:0]         drop_amt;
    logic               out_load;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept_in = in_valid & in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        logic [1:0] c;
        c = (in_data.priority_req == CLS_DEFAULT) ? in_data.dflt_class
                                                  : in_data.priority_req;
        enq_cls = (c == CLS_DEFAULT) ? CLS_BG : c;
    end

    assign pop_cls = (fill_reg[CLS_CRIT] != '0) ? CLS_CRIT :
                     (fill_reg[CLS_USER] != '0) ? CLS_USER : CLS_BG;

    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        fill_next        = fill_reg;
        serial_seq_next  = serial_seq_reg;
        wifi_seq_next    = wifi_seq_reg;
        serial_drop_next = serial_drop_reg;
        wifi_drop_next   = wifi_drop_reg;
        sb_next          = sb_reg;
        wb_next          = wb_reg;
        cnt_next         = cnt_reg;
        meta_next        = meta_reg;
        state_next       = state_reg;
        drop_amt         = 2'd0;
        out_load         = 1'b0;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_waddr        = addr_of(enq_cls, tail_reg[enq_cls]);
        ram_wdata        = {in_data.timestamp, in_data.value, in_data.source_id,
                            in_data.value_type};
        ram_raddr        = addr_of(pop_cls, head_reg[pop_cls]);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in && in_data.mode == MODE_ENQUEUE)
                begin
                    priority if (fill_reg[enq_cls] != FULL)
                    begin
                        ram_we             = 1'b1;
                        tail_next[enq_cls] = next_idx(tail_reg[enq_cls]);
                        fill_next[enq_cls] = FW'(fill_reg[enq_cls] + 1'b1);
                    end
                    else if (enq_cls == CLS_BG)
                    begin
                        drop_amt = 2'd1;
                    end
                    else if (fill_reg[CLS_BG] != '0)
                    begin
                        // evicting another class frees nothing here: new sample drops too
                        head_next[CLS_BG] = next_idx(head_reg[CLS_BG]);
                        fill_next[CLS_BG] = FW'(fill_reg[CLS_BG] - 1'b1);
                        drop_amt          = 2'd2;
                    end
                    else if (enq_cls == CLS_CRIT && fill_reg[CLS_USER] != '0)
                    begin
                        head_next[CLS_USER] = next_idx(head_reg[CLS_USER]);
                        fill_next[CLS_USER] = FW'(fill_reg[CLS_USER] - 1'b1);
                        drop_amt            = 2'd2;
                    end
                    else
                    begin
                        // overwrite own oldest, fill stays full
                        ram_we             = 1'b1;
                        head_next[enq_cls] = next_idx(head_reg[enq_cls]);
                        tail_next[enq_cls] = next_idx(tail_reg[enq_cls]);
                        drop_amt           = 2'd1;
                    end
                end
                else if (accept_in)
                begin
                    sb_next  = serial_en_reg ? budget_of(serial_bw_reg) : '0;
                    wb_next  = wifi_en_reg ? budget_of(wifi_bw_reg) : '0;
                    cnt_next = '0;
                    if ((sb_next != '0 || wb_next != '0) &&
                        (fill_reg[CLS_CRIT] != '0 || fill_reg[CLS_USER] != '0 ||
                         fill_reg[CLS_BG] != '0))
                    begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ram_re             = 1'b1;
                    head_next[pop_cls] = next_idx(head_reg[pop_cls]);
                    fill_next[pop_cls] = FW'(fill_reg[pop_cls] - 1'b1);
                    meta_next          = '0;
                    meta_next.cls      = pop_cls;
                    if (sb_reg != '0)
                    begin
                        meta_next.to_serial    = 1'b1;
                        meta_next.serial_seq   = serial_seq_reg;
                        meta_next.serial_drops = serial_drop_reg;
                        serial_seq_next        = SEQ_W'(serial_seq_reg + 1'b1);
                        serial_drop_next       = '0;
                        sb_next                = SEQ_W'(sb_reg - 1'b1);
                    end
                    if (wb_reg != '0 && pop_cls != CLS_BG)
                    begin
                        if (wifi_stream_reg)
                        begin
                            meta_next.to_wifi    = 1'b1;
                            meta_next.wifi_seq   = wifi_seq_reg;
                            meta_next.wifi_drops = wifi_drop_reg;
                            wifi_seq_next        = SEQ_W'(wifi_seq_reg + 1'b1);
                            wifi_drop_next       = '0;
                        end
                        wb_next = SEQ_W'(wb_reg - 1'b1);
                    end
                    cnt_next       = CNT_W'(cnt_reg + 1'b1);
                    // last when the next round would not start
                    meta_next.last = !((sb_next != '0 || wb_next != '0) &&
                                       cnt_next != CNT_W'(MAX_RESULTS) &&
                                       (fill_next[CLS_CRIT] != '0 ||
                                        fill_next[CLS_USER] != '0 ||
                                        fill_next[CLS_BG] != '0));
                    state_next     = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                out_load   = 1'b1;
                state_next = meta_reg.last ? ST_IDLE : ST_POP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (drop_amt != 2'd0)
        begin
            serial_drop_next = sat_add(serial_drop_reg, drop_amt);
            wifi_drop_next   = sat_add(wifi_drop_reg, drop_amt);
        end
    end

    // output register is free whenever a pop is allowed, so a load never overwrites a beat
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            serial_en_reg   <= 1'b1;
            serial_bw_reg   <= BW_NORMAL;
            wifi_en_reg     <= 1'b0;
            wifi_bw_reg     <= BW_NEVER;
            wifi_stream_reg <= 1'b1;
            for (int i = 0; i < NUM_CLASS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            serial_seq_reg  <= '0;
            wifi_seq_reg    <= '0;
            serial_drop_reg <= '0;
            wifi_drop_reg   <= '0;
            sb_reg          <= '0;
            wb_reg          <= '0;
            cnt_reg         <= '0;
            meta_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            fill_reg        <= fill_next;
            serial_seq_reg  <= serial_seq_next;
            wifi_seq_reg    <= wifi_seq_next;
            serial_drop_reg <= serial_drop_next;
            wifi_drop_reg   <= wifi_drop_next;
            sb_reg          <= sb_next;
            wb_reg          <= wb_next;
            cnt_reg         <= cnt_next;
            meta_reg        <= meta_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SERIAL_ENABLE:    serial_en_reg   <= cfg_data[0];
                    CFG_SERIAL_BANDWIDTH: serial_bw_reg   <= cfg_data[2:0];
                    CFG_WIFI_ENABLE:      wifi_en_reg     <= cfg_data[0];
                    CFG_WIFI_BANDWIDTH:   wifi_bw_reg     <= cfg_data[2:0];
                    CFG_WIFI_STREAM:      wifi_stream_reg <= cfg_data[0];
                    default:              ;
                endcase
            end
        end
    end

    // output payload, no reset
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.priority_res   <= meta_reg.cls;
            out_reg.value_type_res <= ram_rdata[1:0];
            out_reg.source_id_res  <= ram_rdata[9:2];
            out_reg.value_res      <= ram_rdata[41:10];
            out_reg.timestamp_res  <= ram_rdata[73:42];
            out_reg.to_serial      <= meta_reg.to_serial;
            out_reg.to_wifi        <= meta_reg.to_wifi;
            out_reg.serial_seq     <= meta_reg.serial_seq;
            out_reg.wifi_seq       <= meta_reg.wifi_seq;
            out_reg.serial_drops   <= meta_reg.serial_drops;
            out_reg.wifi_drops     <= meta_reg.wifi_drops;
            out_reg.last           <= meta_reg.last;
        end
    end

    plqd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_D)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== src/plqd_checker.sv =====
// port-level checker for the priority log queue drain, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module plqd_props
    import plqd_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input plqd_in_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input plqd_out_t out_data
);

    // a stalled beat keeps its payload
    `PLQD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output beat changed while stalled")

    `PLQD_ASSERT(a_serial_quiet, out_valid && !out_data.to_serial |-> out_data.serial_seq == 16'd0 && out_data.serial_drops == 16'd0, "serial fields set without a serial send")

    `PLQD_ASSERT(a_wifi_quiet, out_valid && !out_data.to_wifi |-> out_data.wifi_seq == 16'd0 && out_data.wifi_drops == 16'd0, "wifi fields set without a wifi send")

    // background samples never go out on wifi
    `PLQD_ASSERT(a_wifi_class, out_valid && out_data.to_wifi |-> out_data.priority_res != CLS_BG && out_data.priority_res != CLS_DEFAULT, "wifi send of a background sample")

    // an enqueue beat taken while no output beat is pending never produces an output beat
    `PLQD_ASSERT_NEXT(a_no_beat_after_enqueue, in_valid && in_ready && in_data.mode == MODE_ENQUEUE && !out_valid, !out_valid, "output beat caused by an enqueue")

endmodule

bind priority_log_queue_drain plqd_props u_plqd_checker (.*);
